// ===== hw/rtl/pqe_pkg.sv =====
// ----------------------------------------------------------------------------
// pqe_pkg: shared types and constants of the three-class event queue
// Word formats of both channels, the decoded operation handed from the
// front end to the back end, class and command codes, and sizing constants.
// ----------------------------------------------------------------------------
package pqe_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TAG_W       = 16;
    localparam int NUM_CLASSES = 3;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = $clog2(NUM_CLASSES * QUEUE_DEPTH + 1);
    localparam int LEVEL_W = 8;
    localparam int QTOT_W  = 8;
    localparam int CMP_W   = (SUM_W > LEVEL_W) ? SUM_W : LEVEL_W;

    // Operation queue between front end and back end.
    localparam int OPQ_DEPTH = 2;
    localparam int OPQ_AW    = $clog2(OPQ_DEPTH);
    localparam int OPQ_CW    = $clog2(OPQ_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLOAD_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_READY_LEVEL    = 1'b1;
    localparam logic [LEVEL_W-1:0]   OVERLOAD_LEVEL_RST = 8'd32;
    localparam logic [LEVEL_W-1:0]   READY_LEVEL_RST    = 8'd8;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_SERVICE = 1'b1;

    localparam logic [1:0] CLS_LOW  = 2'd0;
    localparam logic [1:0] CLS_DATA = 2'd1;
    localparam logic [1:0] CLS_HIGH = 2'd2;

    typedef struct packed {
        logic             command;
        logic [1:0]       priority_class;
        logic [TAG_W-1:0] event_tag;
    } t_cmd_word;

    typedef struct packed {
        logic              accepted;
        logic              keep_sending;
        logic              out_valid;
        logic [1:0]        out_class;
        logic [TAG_W-1:0]  out_tag;
        logic              ready_notify;
        logic [QTOT_W-1:0] queue_total;
    } t_res_word;

    // Decoded operation: service or enqueue, and whether the class names a FIFO.
    typedef struct packed {
        logic             service;
        logic             enq_ok;
        logic [1:0]       cls;
        logic [TAG_W-1:0] tag;
    } t_op;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_back_state;

endpackage

// ===== hw/rtl/three_class_priority_event_queue.sv =====
// ----------------------------------------------------------------------------
// three_class_priority_event_queue: strict-priority event queue, three classes
// Low, data and high class FIFOs of event tags with watermark backpressure.
// ----------------------------------------------------------------------------
// Usage:
// Command words enter on i_cmd_valid / o_cmd_ready. A word is either an
// enqueue of a tag into its class FIFO or a service that pops the oldest
// tag of the highest non-empty class. Every command word yields exactly one
// result word on o_res_valid / i_res_ready, in command order.
// The front end holds up to two decoded commands, so intake continues while
// the back end works or the result waits. The back end completes an enqueue
// directly and a service through a separate read state, because the tag
// comes from the registered read port of the class RAM; it takes one enqueue
// per cycle while the result is taken, and no new command in a read state.
// Reset empties all FIFOs, clears both overload flags and loads the levels
// with 32 (overload) and 8 (ready). Levels are written through i_cfg_we.
// When the receiver stalls, the result word holds and the back end stops;
// the front end fills and then drops o_cmd_ready.
// ----------------------------------------------------------------------------
module three_class_priority_event_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  pqe_pkg::t_cmd_word            i_cmd_word,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output pqe_pkg::t_res_word            o_res_word,
    input  logic                          i_cfg_we,
    input  logic [pqe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pqe_pkg::LEVEL_W-1:0]   i_cfg_data
);

    logic         w_op_valid;
    logic         w_op_take;
    pqe_pkg::t_op w_op;

    pqe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_ready (o_cmd_ready),
        .i_cmd_word  (i_cmd_word),
        .o_op_valid  (w_op_valid),
        .o_op        (w_op),
        .i_op_take   (w_op_take)
    );

    pqe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_op_valid),
        .i_op        (w_op),
        .o_op_take   (w_op_take),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res_word  (o_res_word)
    );

endmodule

// ===== hw/rtl/pqe_ram.sv =====
// ----------------------------------------------------------------------------
// pqe_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pqe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pqe_front.sv =====
// ----------------------------------------------------------------------------
// pqe_front: command intake and classification
// Accepts command words, decodes them into operations and holds them in a
// short queue that the back end drains at its own pace.
// ----------------------------------------------------------------------------
module pqe_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  pqe_pkg::t_cmd_word i_cmd_word,
    output logic               o_op_valid,
    output pqe_pkg::t_op       o_op,
    input  logic               i_op_take
);

    pqe_pkg::t_op                r_q [pqe_pkg::OPQ_DEPTH];
    logic [pqe_pkg::OPQ_AW-1:0]  r_wr;
    logic [pqe_pkg::OPQ_AW-1:0]  r_rd;
    logic [pqe_pkg::OPQ_CW-1:0]  r_cnt;
    logic [pqe_pkg::OPQ_AW-1:0]  n_wr;
    logic [pqe_pkg::OPQ_AW-1:0]  n_rd;
    logic [pqe_pkg::OPQ_CW-1:0]  n_cnt;
    logic                        w_push;
    logic                        w_pop;
    pqe_pkg::t_op                w_op;

    assign o_cmd_ready = (r_cnt != pqe_pkg::OPQ_CW'(pqe_pkg::OPQ_DEPTH));
    assign o_op_valid  = (r_cnt != '0);
    assign o_op        = r_q[r_rd];
    assign w_push      = i_cmd_valid && o_cmd_ready;
    assign w_pop       = i_op_take && o_op_valid;

    always_comb begin
        w_op.service = (i_cmd_word.command == pqe_pkg::CMD_SERVICE);
        // The unused class code is kept as an enqueue that stores nothing.
        w_op.enq_ok  = (i_cmd_word.priority_class == pqe_pkg::CLS_LOW)  ||
                       (i_cmd_word.priority_class == pqe_pkg::CLS_DATA) ||
                       (i_cmd_word.priority_class == pqe_pkg::CLS_HIGH);
        w_op.cls     = i_cmd_word.priority_class;
        w_op.tag     = i_cmd_word.event_tag;
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == pqe_pkg::OPQ_AW'(pqe_pkg::OPQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == pqe_pkg::OPQ_AW'(pqe_pkg::OPQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_op;
        end
    end

endmodule

// ===== hw/rtl/pqe_back.sv =====
// ----------------------------------------------------------------------------
// pqe_back: queue engine
// Executes enqueue and service operations on the three class FIFOs, keeps
// the occupancy counts and the overload flags, and holds the result word.
// ----------------------------------------------------------------------------
module pqe_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_op_valid,
    input  pqe_pkg::t_op                        i_op,
    output logic                                o_op_take,
    input  logic                                i_cfg_we,
    input  logic [pqe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pqe_pkg::LEVEL_W-1:0]         i_cfg_data,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output pqe_pkg::t_res_word                  o_res_word
);

    pqe_pkg::t_back_state              r_state;
    pqe_pkg::t_back_state              n_state;
    logic [pqe_pkg::CNT_W-1:0]         r_cnt    [pqe_pkg::NUM_CLASSES];
    logic [pqe_pkg::CNT_W-1:0]         n_cnt    [pqe_pkg::NUM_CLASSES];
    logic [pqe_pkg::PTR_W-1:0]         r_rd_ptr [pqe_pkg::NUM_CLASSES];
    logic [pqe_pkg::PTR_W-1:0]         n_rd_ptr [pqe_pkg::NUM_CLASSES];
    logic [pqe_pkg::PTR_W-1:0]         r_wr_ptr [pqe_pkg::NUM_CLASSES];
    logic [pqe_pkg::PTR_W-1:0]         n_wr_ptr [pqe_pkg::NUM_CLASSES];
    logic                              r_main_ovl;
    logic                              n_main_ovl;
    logic                              r_low_ovl;
    logic                              n_low_ovl;
    logic [pqe_pkg::LEVEL_W-1:0]       r_ovl_level;
    logic [pqe_pkg::LEVEL_W-1:0]       r_rdy_level;
    logic                              r_res_valid;
    logic                              n_res_valid;
    pqe_pkg::t_res_word                r_res;
    pqe_pkg::t_res_word                n_res;
    pqe_pkg::t_res_word                r_pend;
    pqe_pkg::t_res_word                n_pend;
    logic [1:0]                        r_src;
    logic [1:0]                        n_src;

    logic                              w_take;
    logic                              w_load;
    logic                              w_enq;
    logic                              w_svc;
    logic                              w_accepted;
    logic                              w_popped;
    logic                              w_ready;
    logic [1:0]                        w_src;
    logic [pqe_pkg::CMP_W-1:0]         w_total;
    logic [pqe_pkg::CMP_W-1:0]         w_hd_total;
    logic [pqe_pkg::CMP_W-1:0]         w_ovl_cmp;
    logic [pqe_pkg::CMP_W-1:0]         w_rdy_cmp;
    logic [pqe_pkg::NUM_CLASSES-1:0]   w_we;
    logic [pqe_pkg::TAG_W-1:0]         w_rdata  [pqe_pkg::NUM_CLASSES];
    logic [pqe_pkg::TAG_W-1:0]         w_sel_tag;

    function automatic logic [pqe_pkg::PTR_W-1:0] ptr_next(
        input logic [pqe_pkg::PTR_W-1:0] p
    );
        return (p == pqe_pkg::PTR_W'(pqe_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    for (genvar c = 0; c < pqe_pkg::NUM_CLASSES; c++) begin : g_fifo
        // Each RAM reads at its head pointer every cycle, so the head entry
        // sits in the read register in the cycle after a service pops it.
        pqe_ram #(
            .WIDTH (pqe_pkg::TAG_W),
            .DEPTH (pqe_pkg::QUEUE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[c]),
            .i_waddr (r_wr_ptr[c]),
            .i_wdata (i_op.tag),
            .i_raddr (r_rd_ptr[c]),
            .o_rdata (w_rdata[c])
        );
    end

    assign w_take    = (r_state == pqe_pkg::BK_IDLE) && i_op_valid &&
                       (!r_res_valid || i_res_ready);
    assign w_enq     = w_take && !i_op.service;
    assign w_svc     = w_take && i_op.service;
    assign o_op_take = w_take;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pqe_pkg::BK_IDLE: begin
                if (w_svc) begin
                    n_state = pqe_pkg::BK_READ;
                end
            end
            pqe_pkg::BK_READ: begin
                n_state = pqe_pkg::BK_IDLE;
            end
            default: begin
                n_state = pqe_pkg::BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_cnt      = r_cnt;
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_main_ovl = r_main_ovl;
        n_low_ovl  = r_low_ovl;
        n_res      = r_res;
        n_pend     = r_pend;
        n_src      = r_src;
        w_we       = '0;
        w_accepted = 1'b0;
        w_popped   = 1'b0;
        w_ready    = 1'b0;
        w_src      = pqe_pkg::CLS_LOW;
        w_sel_tag  = '0;

        if (w_enq) begin
            for (int c = 0; c < pqe_pkg::NUM_CLASSES; c++) begin
                if (i_op.enq_ok && (i_op.cls == 2'(c)) &&
                    (r_cnt[c] != pqe_pkg::CNT_W'(pqe_pkg::QUEUE_DEPTH))) begin
                    w_we[c]     = 1'b1;
                    n_wr_ptr[c] = ptr_next(r_wr_ptr[c]);
                    n_cnt[c]    = r_cnt[c] + 1'b1;
                    w_accepted  = 1'b1;
                end
            end
        end

        // Strict priority: high, then data, then low.
        if (r_cnt[pqe_pkg::CLS_HIGH] != '0) begin
            w_src = pqe_pkg::CLS_HIGH;
        end else if (r_cnt[pqe_pkg::CLS_DATA] != '0) begin
            w_src = pqe_pkg::CLS_DATA;
        end else begin
            w_src = pqe_pkg::CLS_LOW;
        end
        if (w_svc) begin
            for (int c = 0; c < pqe_pkg::NUM_CLASSES; c++) begin
                if ((w_src == 2'(c)) && (r_cnt[c] != '0)) begin
                    n_rd_ptr[c] = ptr_next(r_rd_ptr[c]);
                    n_cnt[c]    = r_cnt[c] - 1'b1;
                    w_popped    = 1'b1;
                end
            end
        end

        // Counts after this operation.
        w_total    = pqe_pkg::CMP_W'(n_cnt[0]) + pqe_pkg::CMP_W'(n_cnt[1]) +
                     pqe_pkg::CMP_W'(n_cnt[2]);
        w_hd_total = pqe_pkg::CMP_W'(n_cnt[pqe_pkg::CLS_DATA]) +
                     pqe_pkg::CMP_W'(n_cnt[pqe_pkg::CLS_HIGH]);
        w_ovl_cmp  = pqe_pkg::CMP_W'(r_ovl_level);
        w_rdy_cmp  = pqe_pkg::CMP_W'(r_rdy_level);

        if (w_enq) begin
            n_res              = '0;
            n_res.accepted     = w_accepted;
            n_res.queue_total  = w_total[pqe_pkg::QTOT_W-1:0];
            if (i_op.cls == pqe_pkg::CLS_LOW) begin
                if (w_total >= w_ovl_cmp) begin
                    n_low_ovl = 1'b1;
                end
                n_res.keep_sending = !n_low_ovl;
            end else begin
                // Data, high and the unused class answer from the main flag.
                if (w_hd_total >= w_ovl_cmp) begin
                    n_main_ovl = 1'b1;
                    n_low_ovl  = 1'b1;
                end
                n_res.keep_sending = !n_main_ovl;
            end
        end

        if (w_svc) begin
            if ((r_main_ovl || r_low_ovl) && (w_total <= w_rdy_cmp)) begin
                n_main_ovl = 1'b0;
                n_low_ovl  = 1'b0;
                w_ready    = 1'b1;
            end
            n_src               = w_src;
            n_pend              = '0;
            n_pend.out_valid    = w_popped;
            n_pend.out_class    = w_popped ? w_src : pqe_pkg::CLS_LOW;
            n_pend.ready_notify = w_ready;
            n_pend.queue_total  = w_total[pqe_pkg::QTOT_W-1:0];
        end

        for (int c = 0; c < pqe_pkg::NUM_CLASSES; c++) begin
            if (r_src == 2'(c)) begin
                w_sel_tag = w_rdata[c];
            end
        end
        if (r_state == pqe_pkg::BK_READ) begin
            n_res = r_pend;
            if (r_pend.out_valid) begin
                n_res.out_tag = w_sel_tag;
            end
        end

        w_load      = w_enq || (r_state == pqe_pkg::BK_READ);
        n_res_valid = w_load || (r_res_valid && !i_res_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pqe_pkg::BK_IDLE;
            r_main_ovl  <= 1'b0;
            r_low_ovl   <= 1'b0;
            r_res_valid <= 1'b0;
            r_ovl_level <= pqe_pkg::OVERLOAD_LEVEL_RST;
            r_rdy_level <= pqe_pkg::READY_LEVEL_RST;
            for (int c = 0; c < pqe_pkg::NUM_CLASSES; c++) begin
                r_cnt[c]    <= '0;
                r_rd_ptr[c] <= '0;
                r_wr_ptr[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_main_ovl  <= n_main_ovl;
            r_low_ovl   <= n_low_ovl;
            r_res_valid <= n_res_valid;
            r_cnt       <= n_cnt;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pqe_pkg::REG_OVERLOAD_LEVEL: r_ovl_level <= i_cfg_data;
                    pqe_pkg::REG_READY_LEVEL:    r_rdy_level <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_pend <= n_pend;
        r_src  <= n_src;
    end

    assign o_res_valid = r_res_valid;
    assign o_res_word  = r_res;

`ifndef ASSERT_OFF
    // Setting the main flag always sets the low flag as well.
    a_main_implies_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_main_ovl |-> r_low_ovl)
        else $error("main overload flag set without low overload flag");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= pqe_pkg::CNT_W'(pqe_pkg::QUEUE_DEPTH)) &&
        (r_cnt[1] <= pqe_pkg::CNT_W'(pqe_pkg::QUEUE_DEPTH)) &&
        (r_cnt[2] <= pqe_pkg::CNT_W'(pqe_pkg::QUEUE_DEPTH)))
        else $error("class FIFO count beyond depth");

    // The read cycle of a service always finds the result register free.
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pqe_pkg::BK_READ) |-> !r_res_valid)
        else $error("result register busy during service read");

    a_notify_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.ready_notify) |-> (!r_main_ovl && !r_low_ovl))
        else $error("ready word delivered while overload flags set");

    a_service_takes_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_svc |=> (r_state == pqe_pkg::BK_READ))
        else $error("service did not enter the read cycle");
`endif

endmodule
